// ===== design/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg: shared definitions for the positional list engine
// Field widths, command and status codes, and the decoded command record
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int CAPACITY_MAX    = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int LENGTH_W = 5;

    // Widths of the command record, sized for the largest supported list.
    localparam int IDX_MAX_W = $clog2(CAPACITY_MAX);
    localparam int LEN_MAX_W = $clog2(CAPACITY_MAX + 1);

    localparam logic [CMD_W-1:0] CMD_HEAD_INS = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TAIL_INS = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POS_INS  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_HEAD_DEL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TAIL_DEL = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POS_DEL  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ_OUT = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_DELETE,
        OP_REPORT,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                         op;
        logic [IDX_MAX_W-1:0]        idx;
        logic signed [VALUE_W-1:0]   value;
        logic [STATUS_W-1:0]         status;
        logic [LEN_MAX_W-1:0]        len;
    } cmd_rec_t;

endpackage

// ===== design/ple_front.sv =====
// ----------------------------------------------------------------------------
// ple_front: command classifier
// Decides the status and target index of each command against a running
// copy of the list length, so that the back end does no checks of its own.
// ----------------------------------------------------------------------------
module ple_front #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [ple_pkg::CMD_W-1:0]          command,
    input  logic signed [ple_pkg::VALUE_W-1:0] item_value,
    input  logic [ple_pkg::POS_W-1:0]          position,
    output logic                               push,
    output ple_pkg::cmd_rec_t                  rec
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [MW-1:0] c_ext;
    logic [MW-1:0] p_ext;
    logic [MW-1:0] p_minus;
    logic          full;
    logic          empty;

    assign c_ext   = MW'(count_reg);
    assign p_ext   = MW'(position);
    assign p_minus = p_ext - 1'b1;
    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        push       = accept;
        rec.op     = ple_pkg::OP_REPORT;
        rec.idx    = '0;
        rec.value  = item_value;
        rec.status = ple_pkg::ST_OK;
        unique case (command)
            ple_pkg::CMD_HEAD_INS:
            begin
                if (full)
                    rec.status = ple_pkg::ST_FULL;
                else
                begin
                    rec.op     = ple_pkg::OP_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            ple_pkg::CMD_TAIL_INS:
            begin
                if (full)
                    rec.status = ple_pkg::ST_FULL;
                else
                begin
                    rec.op     = ple_pkg::OP_INSERT;
                    rec.idx    = ple_pkg::IDX_MAX_W'(count_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            ple_pkg::CMD_POS_INS:
            begin
                if (full)
                    rec.status = ple_pkg::ST_FULL;
                else if (p_ext == '0 || p_minus > c_ext)
                    rec.status = ple_pkg::ST_BADPOS;
                else
                begin
                    rec.op     = ple_pkg::OP_INSERT;
                    rec.idx    = ple_pkg::IDX_MAX_W'(p_minus);
                    count_next = count_reg + 1'b1;
                end
            end
            ple_pkg::CMD_HEAD_DEL:
            begin
                if (empty)
                    rec.status = ple_pkg::ST_EMPTY;
                else
                begin
                    rec.op     = ple_pkg::OP_DELETE;
                    count_next = count_reg - 1'b1;
                end
            end
            ple_pkg::CMD_TAIL_DEL:
            begin
                if (empty)
                    rec.status = ple_pkg::ST_EMPTY;
                else
                begin
                    rec.op     = ple_pkg::OP_DELETE;
                    rec.idx    = ple_pkg::IDX_MAX_W'(count_reg - 1'b1);
                    count_next = count_reg - 1'b1;
                end
            end
            ple_pkg::CMD_POS_DEL:
            begin
                if (empty)
                    rec.status = ple_pkg::ST_EMPTY;
                else if (p_ext == '0 || p_ext > c_ext)
                    rec.status = ple_pkg::ST_BADPOS;
                else
                begin
                    rec.op     = ple_pkg::OP_DELETE;
                    rec.idx    = ple_pkg::IDX_MAX_W'(p_minus);
                    count_next = count_reg - 1'b1;
                end
            end
            ple_pkg::CMD_READ_OUT:
            begin
                if (empty)
                    rec.status = ple_pkg::ST_EMPTY;
                else
                    rec.op = ple_pkg::OP_READ;
            end
            default:
            begin
                // The unused code is dropped without a result.
                push = 1'b0;
            end
        endcase
        rec.len = ple_pkg::LEN_MAX_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (push)
            count_reg <= count_next;
    end

endmodule

// ===== design/ple_queue.sv =====
// ----------------------------------------------------------------------------
// ple_queue: command queue
// Small first-in first-out buffer of classified commands between the
// front end and the back end.
// ----------------------------------------------------------------------------
module ple_queue #(
    parameter int DEPTH = ple_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ple_pkg::cmd_rec_t din,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output ple_pkg::cmd_rec_t dout
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    ple_pkg::cmd_rec_t slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [NW-1:0]     fill_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (fill_reg == NW'(DEPTH));
    assign valid   = (fill_reg != '0);
    assign dout    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= din;
    end

endmodule

// ===== design/ple_back.sv =====
// ----------------------------------------------------------------------------
// ple_back: list storage and result sequencer
// Holds the list in a row of cells that shift as one for inserts and
// deletes, and rotates the row to stream it out during a read-out.
// ----------------------------------------------------------------------------
module ple_back #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  ple_pkg::cmd_rec_t                   head,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ple_pkg::VALUE_W-1:0]  out_value,
    output logic [ple_pkg::STATUS_W-1:0]        status,
    output logic [ple_pkg::LENGTH_W-1:0]        list_length,
    output logic                                last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_READ
    } state_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_INS,
        SH_DEL,
        SH_ROT
    } shift_t;

    state_t                              state_reg, state_next;
    logic [CW-1:0]                       rd_len_reg, rd_len_next;
    logic [CW-1:0]                       rd_cnt_reg, rd_cnt_next;
    logic                                out_valid_reg, out_valid_next;
    logic signed [ple_pkg::VALUE_W-1:0]  out_value_reg, out_value_next;
    logic [ple_pkg::STATUS_W-1:0]        status_reg, status_next;
    logic [ple_pkg::LENGTH_W-1:0]        length_reg, length_next;
    logic                                last_reg, last_next;

    logic signed [ple_pkg::VALUE_W-1:0]  cells_reg [CAPACITY];
    logic signed [ple_pkg::VALUE_W-1:0]  cells_next [CAPACITY];

    shift_t        sh_op;
    logic [IW-1:0] sh_idx;
    logic [CW-1:0] head_len;
    logic [CW-1:0] rot_len;
    logic [IW-1:0] rot_end;
    logic          can_load;

    assign head_len = CW'(head.len);
    assign sh_idx   = IW'(head.idx);
    assign rot_len  = (state_reg == BK_READ) ? rd_len_reg : head_len;
    assign rot_end  = IW'(rot_len - 1'b1);
    assign can_load = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        rd_len_next    = rd_len_reg;
        rd_cnt_next    = rd_cnt_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        length_next    = length_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        sh_op          = SH_NONE;
        if (can_load)
            out_valid_next = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && can_load)
                begin
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    status_next    = head.status;
                    length_next    = ple_pkg::LENGTH_W'(head_len);
                    last_next      = 1'b1;
                    unique case (head.op)
                        ple_pkg::OP_INSERT: sh_op = SH_INS;
                        ple_pkg::OP_DELETE: sh_op = SH_DEL;
                        ple_pkg::OP_REPORT: sh_op = SH_NONE;
                        ple_pkg::OP_READ:
                        begin
                            out_value_next = cells_reg[0];
                            sh_op          = SH_ROT;
                            if (head_len != CW'(1))
                            begin
                                last_next   = 1'b0;
                                state_next  = BK_READ;
                                rd_cnt_next = CW'(1);
                                rd_len_next = head_len;
                            end
                        end
                        default: sh_op = SH_NONE;
                    endcase
                end
            end
            BK_READ:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = cells_reg[0];
                    status_next    = ple_pkg::ST_OK;
                    length_next    = ple_pkg::LENGTH_W'(rd_len_reg);
                    last_next      = (CW'(rd_cnt_reg + 1'b1) == rd_len_reg);
                    sh_op          = SH_ROT;
                    rd_cnt_next    = rd_cnt_reg + 1'b1;
                    if (CW'(rd_cnt_reg + 1'b1) == rd_len_reg)
                        state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // After a full rotation of the occupied cells the list is back in order.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cells_next[i] = cells_reg[i];
            unique case (sh_op)
                SH_INS:
                begin
                    if (IW'(i) == sh_idx)
                        cells_next[i] = head.value;
                    else if (i > 0 && IW'(i) > sh_idx)
                        cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                end
                SH_DEL:
                begin
                    if (i < CAPACITY - 1 && IW'(i) >= sh_idx)
                        cells_next[i] = cells_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
                SH_ROT:
                begin
                    if (IW'(i) == rot_end)
                        cells_next[i] = cells_reg[0];
                    else if (i < CAPACITY - 1 && IW'(i) < rot_end)
                        cells_next[i] = cells_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
                default: cells_next[i] = cells_reg[i];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
            cells_reg[i] <= cells_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rd_len_reg    <= '0;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            status_reg    <= ple_pkg::ST_OK;
            length_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_len_reg    <= rd_len_next;
            rd_cnt_reg    <= rd_cnt_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            status_reg    <= status_next;
            length_reg    <= length_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign status      = status_reg;
    assign list_length = length_reg;
    assign last        = last_reg;

endmodule

// ===== design/positional_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_unit: ordered list of signed values edited by position
// Front end classifies commands, a short queue decouples it from the back
// end, which shifts the list cells and streams results.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Fields
//  input     in_valid / in_stall  command, item_value, position
//  output    out_valid/ out_stall out_value, status, list_length, last
//
// A command is classified in the cycle it transfers and enters the queue.
// An edit, a refused command or an empty read-out gives one result; a
// read-out of N entries gives N results, one value per cycle while
// out_stall is low, as the cell row rotates through the output register.
// Input stalls only while the command queue is full.
// Reset clears the length, the queue and the output register; no clearing
// pass is needed since cells beyond the length are never read.
//
module positional_list_engine_unit #(
    parameter int CAPACITY    = ple_pkg::CAPACITY_DEF,
    parameter int QUEUE_DEPTH = ple_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ple_pkg::CMD_W-1:0]           command,
    input  logic signed [ple_pkg::VALUE_W-1:0]  item_value,
    input  logic [ple_pkg::POS_W-1:0]           position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ple_pkg::VALUE_W-1:0]  out_value,
    output logic [ple_pkg::STATUS_W-1:0]        status,
    output logic [ple_pkg::LENGTH_W-1:0]        list_length,
    output logic                                last
);

    logic              accept;
    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    ple_pkg::cmd_rec_t rec_in;
    ple_pkg::cmd_rec_t rec_head;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    ple_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .command    (command),
        .item_value (item_value),
        .position   (position),
        .push       (push),
        .rec        (rec_in)
    );

    ple_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (rec_in),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (rec_head)
    );

    ple_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .head        (rec_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_value   (out_value),
        .status      (status),
        .list_length (list_length),
        .last        (last)
    );

`ifndef ASSERT_OFF
    // The back end only takes a command that the queue holds.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");

    // Refused commands and empty read-outs give a single result.
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ple_pkg::ST_OK) |-> last)
        else $error("error status on a result that is not the last");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ple_pkg::ST_EMPTY) |-> (list_length == '0))
        else $error("empty status with a nonzero length");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ple_pkg::ST_FULL)
            |-> (list_length == ple_pkg::LENGTH_W'(CAPACITY)))
        else $error("full status while the list is not full");
`endif

endmodule
